/* design/reciprocal_frequency_meter_macros.svh */
// Assertion helpers shared by the meter's modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef RECIPROCAL_FREQUENCY_METER_MACROS_SVH
`define RECIPROCAL_FREQUENCY_METER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rfm_pkg.sv */
`default_nettype none

package rfm_pkg;

  // Width of the tick counter.
  localparam int COUNT_BITS = 32;
  // Width of the reported frequency and of the clock rate register.
  localparam int FREQ_BITS = 32;
  // Numerator clock_hz + count/2 needs one bit more than its wider operand.
  localparam int NUM_BITS = ((COUNT_BITS - 1 > FREQ_BITS) ? COUNT_BITS - 1 : FREQ_BITS) + 1;
  // Step counter of the divider, one step per numerator bit.
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS);

  localparam logic [FREQ_BITS-1:0] CLOCK_RESET = FREQ_BITS'(48000000);

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_EDGE_A = 2'd1,
    OP_EDGE_B = 2'd2,
    OP_BUTTON = 2'd3
  } op_t;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

`default_nettype wire

/* design/reciprocal_frequency_meter.sv */
// Reciprocal frequency meter. Each item is a clock tick, an edge on signal A or B,
// or a button edge, and each item gives exactly one result carrying the latest
// frequency, the source select and the counter state. Ticks, first edges, button
// edges, ignored edges and zero-count completing edges finish without the divider.
// A completing edge with a nonzero count runs the quotient (clock_hz + count/2) /
// count through one restoring divider that retires a single quotient bit per
// cycle; in_ready stays low until its result is posted. A new item is taken when
// the output register is empty or being emptied in the same cycle. cfg_wdata sets
// clock_hz whenever cfg_we is high.
`default_nettype none

module reciprocal_frequency_meter
  import rfm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [FREQ_BITS-1:0] cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_operation,
  input  wire logic                 in_button_level,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_measure_done,
  output logic [FREQ_BITS-1:0]      out_frequency_hz,
  output logic                      out_source_b,
  output logic                      out_counting
);

  `include "reciprocal_frequency_meter_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [FREQ_BITS-1:0]    clock_hz_r, clock_hz_nxt;
  logic                    select_b_r, select_b_nxt;
  logic                    armed_r, armed_nxt;
  logic                    count_en_r, count_en_nxt;
  logic [COUNT_BITS-1:0]   tick_count_r, tick_count_nxt;
  logic [FREQ_BITS-1:0]    last_freq_r, last_freq_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_done_r, out_done_nxt;
  logic                    out_src_r, out_src_nxt;
  logic                    out_cnt_r, out_cnt_nxt;
  logic                    accept;
  logic                    edge_sel;
  op_t                     op;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic [NUM_BITS-1:0]     numerator;
  logic [FREQ_BITS-1:0]    quotient;

  assign op       = op_t'(in_operation);
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // An edge counts only when it comes from the selected signal.
  assign edge_sel = (op == OP_EDGE_A && !select_b_r) || (op == OP_EDGE_B && select_b_r);

  // Rounded numerator built from the count at the completing edge.
  assign numerator = NUM_BITS'(clock_hz_r) + NUM_BITS'(tick_count_r >> 1);

  // Item sequencer and meter state.
  always_comb begin
    state_nxt      = state_r;
    clock_hz_nxt   = cfg_we ? cfg_wdata : clock_hz_r;
    select_b_nxt   = select_b_r;
    armed_nxt      = armed_r;
    count_en_nxt   = count_en_r;
    tick_count_nxt = tick_count_r;
    last_freq_nxt  = last_freq_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_done_nxt   = out_done_r;
    out_src_nxt    = out_src_r;
    out_cnt_nxt    = out_cnt_r;
    div_req.start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_done_nxt = 1'b0;
          unique case (op)
            OP_TICK: begin
              if (count_en_r) begin
                tick_count_nxt = tick_count_r + COUNT_BITS'(1);
              end
            end
            OP_EDGE_A, OP_EDGE_B: begin
              if (edge_sel) begin
                if (!armed_r) begin
                  tick_count_nxt = '0;
                  count_en_nxt   = 1'b1;
                  armed_nxt      = 1'b1;
                end else begin
                  count_en_nxt = 1'b0;
                  armed_nxt    = 1'b0;
                  out_done_nxt = 1'b1;
                  if (tick_count_r == '0) begin
                    last_freq_nxt = '0;
                  end else begin
                    div_req.start = 1'b1;
                    state_nxt     = ST_DIV;
                  end
                end
              end
            end
            OP_BUTTON: begin
              if (in_button_level) begin
                select_b_nxt   = !select_b_r;
                tick_count_nxt = '0;
                count_en_nxt   = 1'b1;
              end
            end
            default: begin
            end
          endcase
          // Items that need no division post their result at once.
          if (state_nxt == ST_IDLE) begin
            out_valid_nxt = 1'b1;
            out_src_nxt   = select_b_nxt;
            out_cnt_nxt   = count_en_nxt;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          last_freq_nxt = quotient;
          out_valid_nxt = 1'b1;
          out_done_nxt  = 1'b1;
          out_src_nxt   = select_b_r;
          out_cnt_nxt   = count_en_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      clock_hz_r   <= CLOCK_RESET;
      select_b_r   <= 1'b0;
      armed_r      <= 1'b0;
      count_en_r   <= 1'b0;
      tick_count_r <= '0;
      last_freq_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clock_hz_r   <= clock_hz_nxt;
      select_b_r   <= select_b_nxt;
      armed_r      <= armed_nxt;
      count_en_r   <= count_en_nxt;
      tick_count_r <= tick_count_nxt;
      last_freq_r  <= last_freq_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_done_r <= out_done_nxt;
    out_src_r  <= out_src_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  rfm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .numerator (numerator),
    .divisor   (tick_count_r),
    .rsp       (div_rsp),
    .quotient  (quotient)
  );

  assign out_valid        = out_valid_r;
  assign out_measure_done = out_done_r;
  assign out_frequency_hz = last_freq_r;
  assign out_source_b     = out_src_r;
  assign out_counting     = out_cnt_r;

  `RFM_ASSERT_NOW(a_div_no_output, state_r == ST_DIV, !out_valid_r,
    "result pending while a division runs")
  `RFM_ASSERT_NOW(a_done_in_div, div_rsp.done, state_r == ST_DIV,
    "divider finished outside the divide state")
  `RFM_ASSERT_NEXT(a_div_result, div_rsp.done, out_valid && out_measure_done && !out_counting,
    "division did not post a completed measurement")
  `RFM_ASSERT_NOW(a_div_busy, state_r == ST_DIV && !div_rsp.done, div_rsp.busy,
    "divide state without a running divider")

endmodule

`default_nettype wire

/* design/rfm_div.sv */
`default_nettype none

// Restoring divider that retires one quotient bit per cycle.
module rfm_div
  import rfm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire div_req_t              req,
  input  wire logic [NUM_BITS-1:0]   numerator,
  input  wire logic [COUNT_BITS-1:0] divisor,
  output div_rsp_t                   rsp,
  output logic [FREQ_BITS-1:0]       quotient
);

  `include "reciprocal_frequency_meter_macros.svh"

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0]   rem_r, rem_nxt;
  logic [NUM_BITS-1:0]     quo_r, quo_nxt;
  logic [COUNT_BITS-1:0]   div_r, div_nxt;
  logic [COUNT_BITS:0]     shifted;
  logic [COUNT_BITS:0]     diff;
  logic                    fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign shifted = {rem_r, quo_r[NUM_BITS-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign fits    = ~diff[COUNT_BITS];

  // Step sequencing: load on start, then one bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_BITS'(NUM_BITS - 1);
      rem_nxt  = '0;
      quo_nxt  = numerator;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
      quo_nxt = {quo_r[NUM_BITS-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_BITS'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quotient = quo_r[FREQ_BITS-1:0];

  `RFM_ASSERT_NOW(a_no_start_busy, req.start, !busy_r, "divider started while busy")
  `RFM_ASSERT_NOW(a_done_idle, done_r, !busy_r, "divider done while still busy")
  `RFM_ASSERT_NEXT(a_last_step, busy_r && cnt_r == '0, done_r && !busy_r,
    "divider missed its final step")

endmodule

`default_nettype wire

/* dv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfm_pkg::*;

  // One reading of the meter, as it leaves the result channel.
  typedef struct packed {
    logic                 done;
    logic [FREQ_BITS-1:0] freq;
    logic                 src_b;
    logic                 counting;
  } reading_t;

  // One row of the directed plan: either a clock rate write or an item.
  typedef struct {
    bit                   is_rate;
    logic [FREQ_BITS-1:0] rate;
    op_t                  op;
    logic                 lvl;
    bit                   typed;
    reading_t             want;
  } plan_row_t;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 66;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [FREQ_BITS-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_operation;
  logic                 in_button_level;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_measure_done;
  logic [FREQ_BITS-1:0] out_frequency_hz;
  logic                 out_source_b;
  logic                 out_counting;

  // Our own copy of the meter state and of the clock rate register.
  logic                 sel_b = 1'b0;
  logic                 armed = 1'b0;
  logic                 run = 1'b0;
  logic [COUNT_BITS-1:0] ticks = '0;
  logic [FREQ_BITS-1:0] freq_last = '0;
  logic [FREQ_BITS-1:0] clock_rate = CLOCK_RESET;

  reading_t  pending_readings[$];
  plan_row_t directed_plan[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        hold_req = 1'b0;
  bit        calm = 1'b0;

  reciprocal_frequency_meter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_button_level  (in_button_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_measure_done (out_measure_done),
    .out_frequency_hz (out_frequency_hz),
    .out_source_b     (out_source_b),
    .out_counting     (out_counting)
  );

  always #4 clk = ~clk;

  // An edge of the selected signal either arms the counter or closes the period.
  function automatic logic take_edge();
    logic [63:0] numer;
    if (!armed) begin
      ticks = '0;
      run   = 1'b1;
      armed = 1'b1;
      return 1'b0;
    end
    run   = 1'b0;
    armed = 1'b0;
    if (ticks == '0) begin
      freq_last = '0;
    end else begin
      numer     = {32'd0, clock_rate} + {33'd0, ticks[COUNT_BITS-1:1]};
      freq_last = FREQ_BITS'(numer / {32'd0, ticks});
    end
    return 1'b1;
  endfunction

  // Advances the meter state by one item and returns the reading it gives.
  function automatic reading_t predict_reading(input op_t op, input logic lvl);
    reading_t r;
    logic     done_now;
    done_now = 1'b0;
    case (op)
      OP_TICK: begin
        if (run) ticks = ticks + 1'b1;
      end
      OP_EDGE_A: begin
        if (!sel_b) done_now = take_edge();
      end
      OP_EDGE_B: begin
        if (sel_b) done_now = take_edge();
      end
      default: begin
        // A confirmed press swaps the source and restarts the count.
        if (lvl) begin
          sel_b = ~sel_b;
          ticks = '0;
          run   = 1'b1;
        end
      end
    endcase
    r.done     = done_now;
    r.freq     = freq_last;
    r.src_b    = sel_b;
    r.counting = run;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Compares the reading on the result channel with the oldest expectation.
  task automatic check_reading();
    reading_t want;
    if (pending_readings.size() == 0) begin
      report_mismatch("reading with nothing expected, frequency", out_frequency_hz, 32'd0);
      return;
    end
    want = pending_readings.pop_front();
    if (out_measure_done !== want.done)
      report_mismatch("measure_done", out_measure_done, want.done);
    if (out_frequency_hz !== want.freq)
      report_mismatch("frequency_hz", out_frequency_hz, want.freq);
    if (out_source_b !== want.src_b)
      report_mismatch("source_b", out_source_b, want.src_b);
    if (out_counting !== want.counting)
      report_mismatch("counting", out_counting, want.counting);
  endtask

  // Offers one item, waits for it to be taken and records its expected reading.
  task automatic send_item(input op_t op, input logic lvl, input bit typed,
                           input reading_t typed_want);
    reading_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_button_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_reading(op, lvl);
    pending_readings.push_back(typed ? typed_want : predicted);
  endtask

  // The rate register is written only once the meter has drained.
  task automatic write_clock(input logic [FREQ_BITS-1:0] rate);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we     <= 1'b0;
    clock_rate = rate;
  endtask

  function automatic void plan_item(input op_t op, input logic lvl, input bit typed,
                                    input reading_t want);
    plan_row_t row;
    row.is_rate = 1'b0;
    row.rate    = '0;
    row.op      = op;
    row.lvl     = lvl;
    row.typed   = typed;
    row.want    = want;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_rate(input logic [FREQ_BITS-1:0] rate);
    plan_row_t row;
    row.is_rate = 1'b1;
    row.rate    = rate;
    row.op      = OP_TICK;
    row.lvl     = 1'b0;
    row.typed   = 1'b0;
    row.want    = '0;
    directed_plan.push_back(row);
  endfunction

  // Random items: mostly measurements on the selected signal, with presses,
  // stray edges on the other signal and occasional long runs of ticks.
  task automatic run_measure_phase(input logic [FREQ_BITS-1:0] rate, input bit pressure);
    int   sent;
    int   tick_run;
    int   pick;
    op_t  op;
    logic lvl;
    write_clock(rate);
    sent     = 0;
    tick_run = 0;
    while (sent < PHASE_ITEMS) begin
      lvl  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (tick_run > 0) begin
        tick_run--;
        op = OP_TICK;
      end else if (pick < 4) begin
        tick_run = $urandom_range(10, 40);
        op       = OP_TICK;
      end else if (pick < 55) begin
        op = OP_TICK;
      end else if (pick < 80) begin
        op = sel_b ? OP_EDGE_B : OP_EDGE_A;
      end else if (pick < 88) begin
        op = sel_b ? OP_EDGE_A : OP_EDGE_B;
      end else if (pick < 96) begin
        op  = OP_BUTTON;
        lvl = 1'b1;
      end else begin
        op  = OP_BUTTON;
        lvl = 1'b0;
      end
      if (pressure && sent == 30) hold_req = 1'b1;
      send_item(op, lvl, 1'b0, '0);
      sent++;
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_reading();
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [FREQ_BITS-1:0] rates[6];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_operation    = OP_TICK;
    in_button_level = 1'b0;
    out_ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan, starting at the reset rate of 48 MHz.
    plan_item(OP_TICK,   1'b0, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b0});  // tick while stopped
    plan_item(OP_EDGE_B, 1'b1, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b0});  // unselected edge
    plan_item(OP_BUTTON, 1'b0, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b0});  // unconfirmed press
    plan_item(OP_EDGE_A, 1'b0, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b1});  // first edge arms
    plan_item(OP_EDGE_A, 1'b0, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b0});  // zero count
    plan_item(OP_EDGE_A, 1'b1, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b1});
    plan_item(OP_TICK,   1'b0, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b1});
    plan_item(OP_EDGE_A, 1'b0, 1'b1, '{1'b1, 32'd48000000, 1'b0, 1'b0});
    plan_item(OP_BUTTON, 1'b1, 1'b1, '{1'b0, 32'd48000000, 1'b1, 1'b1});
    plan_item(OP_EDGE_A, 1'b0, 1'b1, '{1'b0, 32'd48000000, 1'b1, 1'b1});
    plan_item(OP_EDGE_B, 1'b0, 1'b1, '{1'b0, 32'd48000000, 1'b1, 1'b1});
    plan_item(OP_TICK,   1'b1, 1'b0, '0);
    plan_item(OP_TICK,   1'b0, 1'b0, '0);
    // A press while armed swaps back to signal A and keeps the period open.
    plan_item(OP_BUTTON, 1'b1, 1'b1, '{1'b0, 32'd48000000, 1'b0, 1'b1});
    plan_item(OP_TICK,   1'b0, 1'b0, '0);
    plan_item(OP_TICK,   1'b1, 1'b0, '0);
    plan_item(OP_TICK,   1'b0, 1'b0, '0);
    plan_item(OP_EDGE_A, 1'b1, 1'b1, '{1'b1, 32'd16000000, 1'b0, 1'b0});
    plan_item(OP_TICK,   1'b1, 1'b1, '{1'b0, 32'd16000000, 1'b0, 1'b0});
    // Largest rate over a count of one gives the largest frequency.
    plan_rate(32'hFFFF_FFFF);
    plan_item(OP_EDGE_A, 1'b0, 1'b0, '0);
    plan_item(OP_TICK,   1'b0, 1'b0, '0);
    plan_item(OP_EDGE_A, 1'b0, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0});
    // A zero rate leaves only the rounding term.
    plan_rate(32'd0);
    plan_item(OP_EDGE_A, 1'b0, 1'b0, '0);
    plan_item(OP_TICK,   1'b0, 1'b0, '0);
    plan_item(OP_TICK,   1'b0, 1'b0, '0);
    plan_item(OP_EDGE_A, 1'b0, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b0});

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_rate) write_clock(directed_plan[i].rate);
      else send_item(directed_plan[i].op, directed_plan[i].lvl, directed_plan[i].typed,
                     directed_plan[i].want);
    end

    // Random phases over several rates; the last one runs without idling.
    rates[0] = 32'd1;
    rates[1] = 32'hFFFF_FFFF;
    rates[2] = $urandom;
    rates[3] = 32'd0;
    rates[4] = CLOCK_RESET;
    rates[5] = $urandom;
    foreach (rates[p]) begin
      if (p == 5) calm = 1'b1;
      run_measure_phase(rates[p], p == 2);
    end

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
